/* design/jmsp_pkg.sv */
package jmsp_pkg;

    typedef enum logic [5:0] {
        P_DONE, P_SOI1, P_SOI2, P_MARK, P_CODE, P_LEN1, P_LEN2, P_SKIP,
        P_SOF_P, P_SOF_H1, P_SOF_H2, P_SOF_W1, P_SOF_W2, P_SOF_N,
        P_SOF_CID, P_SOF_SAMP, P_SOF_QID,
        P_DQT_INFO, P_DQT_HI, P_DQT_LO,
        P_DHT_INFO, P_DHT_CNT, P_DHT_SYM,
        P_DRI_V1, P_DRI_V2,
        P_SOS_N, P_SOS_CID, P_SOS_TBL, P_SOS_SS, P_SOS_SE, P_SOS_A,
        P_SCAN, P_SCAN_FF
    } phase_t;

    typedef enum logic [2:0] {
        SEG_SKIP, SEG_SOF, SEG_DQT, SEG_DHT, SEG_DRI, SEG_SOS
    } seg_t;

    localparam logic [2:0] K_QUANT = 3'd0;
    localparam logic [2:0] K_HCNT  = 3'd1;
    localparam logic [2:0] K_HSYM  = 3'd2;
    localparam logic [2:0] K_FRAME = 3'd3;
    localparam logic [2:0] K_SCANP = 3'd4;
    localparam logic [2:0] K_DRI   = 3'd5;
    localparam logic [2:0] K_DATA  = 3'd6;
    localparam logic [2:0] K_STAT  = 3'd7;

    localparam logic [5:0] E_SOF2 = 6'd1, E_PREC = 6'd2, E_DIM = 6'd3, E_NC4 = 6'd4,
        E_NC0 = 6'd5, E_CID45 = 6'd6, E_CIDBAD = 6'd7, E_CIDDUP = 6'd8,
        E_SAMP = 6'd9, E_FQID = 6'd10, E_SOFLEN = 6'd11, E_DQTID = 6'd12,
        E_DQTLEN = 6'd13, E_DRILEN = 6'd14, E_DHTID = 6'd15, E_HMANY = 6'd16,
        E_DHTLEN = 6'd17, E_NOSOF = 6'd18, E_SCID = 6'd19, E_SDUP = 6'd20,
        E_SHID = 6'd21, E_NBASE = 6'd22, E_SOSLEN = 6'd23, E_NOSOI = 6'd24,
        E_EOF = 6'd25, E_NOFF = 6'd26, E_EARLY = 6'd27, E_SOFN = 6'd28,
        E_UNK = 6'd29, E_BADSCAN = 6'd30, E_NCOMP = 6'd31, E_UQ = 6'd32,
        E_UDC = 6'd33, E_UAC = 6'd34;

    function automatic logic [5:0] zz_pos(input logic [5:0] i);
        logic [5:0] r;
        case (i)
            6'd0: r = 0;   6'd1: r = 1;   6'd2: r = 8;   6'd3: r = 16;
            6'd4: r = 9;   6'd5: r = 2;   6'd6: r = 3;   6'd7: r = 10;
            6'd8: r = 17;  6'd9: r = 24;  6'd10: r = 32; 6'd11: r = 25;
            6'd12: r = 18; 6'd13: r = 11; 6'd14: r = 4;  6'd15: r = 5;
            6'd16: r = 12; 6'd17: r = 19; 6'd18: r = 26; 6'd19: r = 33;
            6'd20: r = 40; 6'd21: r = 48; 6'd22: r = 41; 6'd23: r = 34;
            6'd24: r = 27; 6'd25: r = 20; 6'd26: r = 13; 6'd27: r = 6;
            6'd28: r = 7;  6'd29: r = 14; 6'd30: r = 21; 6'd31: r = 28;
            6'd32: r = 35; 6'd33: r = 42; 6'd34: r = 49; 6'd35: r = 56;
            6'd36: r = 57; 6'd37: r = 50; 6'd38: r = 43; 6'd39: r = 36;
            6'd40: r = 29; 6'd41: r = 22; 6'd42: r = 15; 6'd43: r = 23;
            6'd44: r = 30; 6'd45: r = 37; 6'd46: r = 44; 6'd47: r = 51;
            6'd48: r = 58; 6'd49: r = 59; 6'd50: r = 52; 6'd51: r = 45;
            6'd52: r = 38; 6'd53: r = 31; 6'd54: r = 39; 6'd55: r = 46;
            6'd56: r = 53; 6'd57: r = 60; 6'd58: r = 61; 6'd59: r = 54;
            6'd60: r = 47; 6'd61: r = 55; 6'd62: r = 62; default: r = 63;
        endcase
        return r;
    endfunction

endpackage

/* design/jpeg_marker_stream_parser.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] byte; tuser[0] start_of_file, tuser[1] end_of_file
// m_axis    | out       | tdata: kind, table_select, entry_index, entry_value, status
// One byte is parsed per cycle while s_axis_tready is high.
// The parse state and a one-deep output register update in the same cycle.
// Input is accepted whenever the output register is empty or being drained.
// Reset is synchronous (aresetn low) and returns the parser to waiting for SOI.
module jpeg_marker_stream_parser
    import jmsp_pkg::*;
#(
    parameter int MAX_HUFF_SYMBOLS = 162
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] start_of_file, [1] end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] kind, [5:3] table_select, [13:6] entry_index, [29:14] entry_value,
    // [35:30] status, [39:36] zero
    output logic [39:0] m_axis_tdata
);

    localparam logic [11:0] MaxSym = 12'(MAX_HUFF_SYMBOLS);

    phase_t      phase_reg, phase_next;
    seg_t        seg_reg, seg_next;
    logic [15:0] seg_len_reg, seg_len_next;
    logic [7:0]  acc_reg, acc_next;
    logic        hz_reg, hz_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [11:0] total_reg, total_next;
    logic [17:0] remain_reg, remain_next;
    logic [7:0]  ncomp_reg, ncomp_next;
    logic        zb_reg, zb_next;
    logic [4:0]  used_reg, used_next;
    logic [2:0]  cur_reg, cur_next;
    logic [2:0]  tsel_reg, tsel_next;
    logic        wide_reg, wide_next;
    logic [7:0]  ns_reg, ns_next;
    logic [7:0]  ss_reg, ss_next;
    logic [7:0]  se_reg, se_next;
    logic [1:0]  qid_reg [3];
    logic [1:0]  qid_next [3];
    logic [1:0]  dcid_reg [3];
    logic [1:0]  dcid_next [3];
    logic [1:0]  acid_reg [3];
    logic [1:0]  acid_next [3];
    logic [3:0]  qset_reg, qset_next, dcset_reg, dcset_next, acset_reg, acset_next;

    logic        ov_reg;
    logic [35:0] od_reg;

    logic        fire, emit;
    logic [2:0]  o_kind, o_sel;
    logic [7:0]  o_idx;
    logic [15:0] o_val;
    logic [5:0]  o_stat;

    assign s_axis_tready = !ov_reg || m_axis_tready;
    assign fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {4'd0, od_reg};

    function automatic logic [5:0] final_check(input logic [7:0] nc, input logic [1:0] q [3],
            input logic [1:0] d [3], input logic [1:0] a [3], input logic [3:0] qs,
            input logic [3:0] ds, input logic [3:0] as_);
        logic [5:0] r;
        r = 6'd0;
        if (nc != 8'd1 && nc != 8'd3) begin
            r = E_NCOMP;
        end else begin
            for (int i = 2; i >= 0; i--) begin
                if (8'(i) < nc) begin
                    if (!qs[q[i]]) r = E_UQ;
                    else if (!ds[d[i]]) r = E_UDC;
                    else if (!as_[a[i]]) r = E_UAC;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        logic        clr;
        phase_t      ph;
        logic [7:0]  b;
        logic [8:0]  id;
        logic [15:0] v;
        logic [17:0] rem;
        logic        err;
        logic [5:0]  ec;
        logic [8:0]  c1;
        logic [11:0] tot;
        logic [5:0]  fc;
        b = s_axis_tdata;
        clr = s_axis_tuser[0];
        ph = clr ? P_SOI1 : phase_reg;
        seg_next = clr ? SEG_SKIP : seg_reg;
        seg_len_next = clr ? 16'd0 : seg_len_reg;
        acc_next = clr ? 8'd0 : acc_reg;
        hz_next = clr ? 1'b0 : hz_reg;
        cnt_next = clr ? 9'd0 : cnt_reg;
        total_next = clr ? 12'd0 : total_reg;
        remain_next = clr ? 18'd0 : remain_reg;
        ncomp_next = clr ? 8'd0 : ncomp_reg;
        zb_next = clr ? 1'b0 : zb_reg;
        used_next = clr ? 5'd0 : used_reg;
        cur_next = clr ? 3'd0 : cur_reg;
        tsel_next = clr ? 3'd0 : tsel_reg;
        wide_next = clr ? 1'b0 : wide_reg;
        ns_next = clr ? 8'd0 : ns_reg;
        ss_next = clr ? 8'd0 : ss_reg;
        se_next = clr ? 8'd0 : se_reg;
        for (int i = 0; i < 3; i++) begin
            qid_next[i] = clr ? 2'd0 : qid_reg[i];
            dcid_next[i] = clr ? 2'd0 : dcid_reg[i];
            acid_next[i] = clr ? 2'd0 : acid_reg[i];
        end
        qset_next = clr ? 4'd0 : qset_reg;
        dcset_next = clr ? 4'd0 : dcset_reg;
        acset_next = clr ? 4'd0 : acset_reg;
        phase_next = ph;
        emit = 1'b0;
        o_kind = K_STAT;
        o_sel = 3'd0;
        o_idx = 8'd0;
        o_val = 16'd0;
        err = 1'b0;
        ec = 6'd0;
        id = 9'd0;
        v = 16'd0;
        rem = 18'd0;
        c1 = cnt_next + 9'd1;
        tot = 12'd0;
        fc = 6'd0;

        if (s_axis_tuser[1]) begin
            if (ph == P_SOI1 || ph == P_SOI2) begin
                err = 1'b1; ec = E_NOSOI;
            end else if (ph != P_DONE) begin
                err = 1'b1; ec = E_EOF;
            end
        end else begin
            case (ph)
                P_SOI1: begin
                    if (b != 8'hFF) begin err = 1'b1; ec = E_NOSOI; end
                    else phase_next = P_SOI2;
                end
                P_SOI2: begin
                    if (b != 8'hD8) begin err = 1'b1; ec = E_NOSOI; end
                    else phase_next = P_MARK;
                end
                P_MARK: begin
                    if (b != 8'hFF) begin err = 1'b1; ec = E_NOFF; end
                    else phase_next = P_CODE;
                end
                P_CODE: begin
                    phase_next = P_LEN1;
                    if (b == 8'hDA) begin
                        if (ncomp_next == 8'd0) begin err = 1'b1; ec = E_NOSOF; end
                        seg_next = SEG_SOS;
                    end else if (b == 8'hC4) seg_next = SEG_DHT;
                    else if (b == 8'hDD) seg_next = SEG_DRI;
                    else if (b == 8'hC0) begin
                        if (ncomp_next != 8'd0) begin err = 1'b1; ec = E_SOF2; end
                        seg_next = SEG_SOF;
                    end else if (b == 8'hDB) seg_next = SEG_DQT;
                    else if (b >= 8'hE0 && b <= 8'hFD || b == 8'hFE || b == 8'hDC
                             || b == 8'hDE || b == 8'hDF) seg_next = SEG_SKIP;
                    else if (b == 8'h01) phase_next = P_MARK;
                    else if (b == 8'hFF) phase_next = P_CODE;
                    else if (b == 8'hD8 || b == 8'hD9) begin err = 1'b1; ec = E_EARLY; end
                    else if (b >= 8'hC0 && b <= 8'hCF) begin err = 1'b1; ec = E_SOFN; end
                    else if (b >= 8'hD0 && b <= 8'hD7) begin err = 1'b1; ec = E_EARLY; end
                    else begin err = 1'b1; ec = E_UNK; end
                end
                P_LEN1: begin
                    acc_next = b; phase_next = P_LEN2;
                end
                P_LEN2: begin
                    v = {acc_next, b};
                    seg_len_next = v;
                    rem = {2'b00, v} - 18'd2;
                    case (seg_next)
                        SEG_SOF: phase_next = P_SOF_P;
                        SEG_DRI: phase_next = P_DRI_V1;
                        SEG_SOS: phase_next = P_SOS_N;
                        SEG_DQT, SEG_DHT: begin
                            remain_next = rem;
                            if (rem[17]) begin
                                err = 1'b1;
                                ec = (seg_next == SEG_DQT) ? E_DQTLEN : E_DHTLEN;
                            end else if (rem == 18'd0) phase_next = P_MARK;
                            else phase_next = (seg_next == SEG_DQT) ? P_DQT_INFO : P_DHT_INFO;
                        end
                        default: begin
                            remain_next = (v >= 16'd2) ? rem : 18'd0;
                            phase_next = (v > 16'd2) ? P_SKIP : P_MARK;
                        end
                    endcase
                end
                P_SKIP: begin
                    remain_next = remain_next - 18'd1;
                    if (remain_next == 18'd0 || remain_next[17]) phase_next = P_MARK;
                end
                P_SOF_P: begin
                    if (b != 8'd8) begin err = 1'b1; ec = E_PREC; end
                    phase_next = P_SOF_H1;
                    emit = 1'b1; o_kind = K_FRAME; o_idx = 8'd0; o_val = {8'd0, b};
                end
                P_SOF_H1: begin acc_next = b; phase_next = P_SOF_H2; end
                P_SOF_H2: begin
                    hz_next = ({acc_next, b} == 16'd0);
                    phase_next = P_SOF_W1;
                    emit = 1'b1; o_kind = K_FRAME; o_idx = 8'd1; o_val = {acc_next, b};
                end
                P_SOF_W1: begin acc_next = b; phase_next = P_SOF_W2; end
                P_SOF_W2: begin
                    if (hz_next || {acc_next, b} == 16'd0) begin err = 1'b1; ec = E_DIM; end
                    phase_next = P_SOF_N;
                    emit = 1'b1; o_kind = K_FRAME; o_idx = 8'd2; o_val = {acc_next, b};
                end
                P_SOF_N: begin
                    ncomp_next = b;
                    if (b == 8'd4) begin err = 1'b1; ec = E_NC4; end
                    else if (b == 8'd0) begin err = 1'b1; ec = E_NC0; end
                    cnt_next = 9'd0; phase_next = P_SOF_CID;
                    emit = 1'b1; o_kind = K_FRAME; o_idx = 8'd3; o_val = {8'd0, b};
                end
                P_SOF_CID: begin
                    if (b == 8'd0) zb_next = 1'b1;
                    id = {1'b0, zb_next ? b + 8'd1 : b};
                    cur_next = 3'(id - 9'd1);
                    if (id == 9'd4 || id == 9'd5) begin err = 1'b1; ec = E_CID45; end
                    else if (id == 9'd0 || id > 9'd5) begin err = 1'b1; ec = E_CIDBAD; end
                    else if (used_next[cur_next]) begin err = 1'b1; ec = E_CIDDUP; end
                    else used_next[cur_next] = 1'b1;
                    phase_next = P_SOF_SAMP;
                    emit = 1'b1; o_kind = K_FRAME;
                    o_idx = 8'(9'd4 + 9'd3 * cnt_next); o_val = {7'd0, id};
                end
                P_SOF_SAMP: begin
                    if (b != 8'h11) begin err = 1'b1; ec = E_SAMP; end
                    phase_next = P_SOF_QID;
                    emit = 1'b1; o_kind = K_FRAME;
                    o_idx = 8'(9'd5 + 9'd3 * cnt_next); o_val = {8'd0, b};
                end
                P_SOF_QID: begin
                    emit = 1'b1; o_kind = K_FRAME;
                    o_idx = 8'(9'd6 + 9'd3 * cnt_next); o_val = {8'd0, b};
                    if (b > 8'd3) begin err = 1'b1; ec = E_FQID; end
                    else begin
                        // cur is 0..2 here: ids 4 and 5 were rejected.
                        if (cur_next < 3'd3) qid_next[cur_next[1:0]] = b[1:0];
                        cnt_next = c1;
                        if (c1 == {1'b0, ncomp_next}) begin
                            if ({2'b00, seg_len_next}
                                != 18'd8 + 18'd3 * {10'd0, ncomp_next}) begin
                                err = 1'b1; ec = E_SOFLEN;
                            end
                            phase_next = P_MARK;
                        end else phase_next = P_SOF_CID;
                    end
                end
                P_DQT_INFO: begin
                    remain_next = remain_next - 18'd1;
                    tsel_next = {1'b0, b[1:0]};
                    if (b[3:0] > 4'd3) begin err = 1'b1; ec = E_DQTID; end
                    qset_next[b[1:0]] = 1'b1;
                    wide_next = (b[7:4] != 4'd0);
                    cnt_next = 9'd0;
                    phase_next = wide_next ? P_DQT_HI : P_DQT_LO;
                end
                P_DQT_HI: begin acc_next = b; phase_next = P_DQT_LO; end
                P_DQT_LO: begin
                    emit = 1'b1; o_kind = K_QUANT; o_sel = tsel_next;
                    o_idx = {2'b00, zz_pos(cnt_next[5:0])};
                    o_val = wide_next ? {acc_next, b} : {8'd0, b};
                    cnt_next = c1;
                    if (c1 >= 9'd64) begin
                        rem = remain_next - (wide_next ? 18'd128 : 18'd64);
                        remain_next = rem;
                        if (rem[17]) begin err = 1'b1; ec = E_DQTLEN; end
                        else phase_next = (rem == 18'd0) ? P_MARK : P_DQT_INFO;
                    end else phase_next = wide_next ? P_DQT_HI : P_DQT_LO;
                end
                P_DHT_INFO: begin
                    if (b[3:0] > 4'd3) begin err = 1'b1; ec = E_DHTID; end
                    tsel_next = {b[7:4] != 4'd0, b[1:0]};
                    if (tsel_next[2]) acset_next[b[1:0]] = 1'b1;
                    else dcset_next[b[1:0]] = 1'b1;
                    cnt_next = 9'd0; total_next = 12'd0;
                    phase_next = P_DHT_CNT;
                end
                P_DHT_CNT: begin
                    // Sixteen counts of at most 255 each fit in twelve bits.
                    tot = total_next + {4'd0, b};
                    total_next = tot;
                    cnt_next = c1;
                    emit = 1'b1; o_kind = K_HCNT; o_sel = tsel_next;
                    o_idx = c1[7:0]; o_val = {4'd0, tot};
                    if (c1 == 9'd16) begin
                        acc_next = 8'd0;
                        if (tot > MaxSym) begin err = 1'b1; ec = E_HMANY; end
                        else if (tot == 12'd0) begin
                            rem = remain_next - 18'd17;
                            remain_next = rem;
                            if (rem[17]) begin err = 1'b1; ec = E_DHTLEN; end
                            else phase_next = (rem == 18'd0) ? P_MARK : P_DHT_INFO;
                        end else phase_next = P_DHT_SYM;
                    end
                end
                P_DHT_SYM: begin
                    emit = 1'b1; o_kind = K_HSYM; o_sel = tsel_next;
                    o_idx = acc_next; o_val = {8'd0, b};
                    acc_next = acc_next + 8'd1;
                    if ({4'd0, acc_next} >= total_next) begin
                        rem = remain_next - 18'd17 - {6'd0, total_next};
                        remain_next = rem;
                        if (rem[17]) begin err = 1'b1; ec = E_DHTLEN; end
                        else phase_next = (rem == 18'd0) ? P_MARK : P_DHT_INFO;
                    end
                end
                P_DRI_V1: begin acc_next = b; phase_next = P_DRI_V2; end
                P_DRI_V2: begin
                    if (seg_len_next != 16'd4) begin err = 1'b1; ec = E_DRILEN; end
                    phase_next = P_MARK;
                    emit = 1'b1; o_kind = K_DRI; o_val = {acc_next, b};
                end
                P_SOS_N: begin
                    ns_next = b; used_next = 5'd0; cnt_next = 9'd0;
                    phase_next = (b != 8'd0) ? P_SOS_CID : P_SOS_SS;
                    emit = 1'b1; o_kind = K_SCANP; o_idx = 8'd0; o_val = {8'd0, b};
                end
                P_SOS_CID: begin
                    id = {1'b0, zb_next ? b + 8'd1 : b};
                    cur_next = 3'(id - 9'd1);
                    if (id == 9'd0 || id > {1'b0, ncomp_next} || id > 9'd3) begin
                        err = 1'b1; ec = E_SCID;
                    end else if (used_next[cur_next]) begin err = 1'b1; ec = E_SDUP; end
                    else used_next[cur_next] = 1'b1;
                    phase_next = P_SOS_TBL;
                    emit = 1'b1; o_kind = K_SCANP;
                    o_idx = 8'(9'd1 + {cnt_next[7:0], 1'b0}); o_val = {7'd0, id};
                end
                P_SOS_TBL: begin
                    emit = 1'b1; o_kind = K_SCANP;
                    o_idx = 8'(9'd2 + {cnt_next[7:0], 1'b0}); o_val = {8'd0, b};
                    if (b[7:4] > 4'd3 || b[3:0] > 4'd3) begin err = 1'b1; ec = E_SHID; end
                    else begin
                        if (cur_next < 3'd3) begin
                            dcid_next[cur_next[1:0]] = b[5:4];
                            acid_next[cur_next[1:0]] = b[1:0];
                        end
                        cnt_next = c1;
                        phase_next = (c1 == {1'b0, ns_next}) ? P_SOS_SS : P_SOS_CID;
                    end
                end
                P_SOS_SS: begin
                    ss_next = b; phase_next = P_SOS_SE;
                    emit = 1'b1; o_kind = K_SCANP;
                    o_idx = 8'(9'd1 + {ns_next, 1'b0}); o_val = {8'd0, b};
                end
                P_SOS_SE: begin
                    se_next = b; phase_next = P_SOS_A;
                    emit = 1'b1; o_kind = K_SCANP;
                    o_idx = 8'(9'd2 + {ns_next, 1'b0}); o_val = {8'd0, b};
                end
                P_SOS_A: begin
                    if (ss_next != 8'd0 || se_next != 8'd63 || b != 8'd0) begin
                        err = 1'b1; ec = E_NBASE;
                    end else if ({1'b0, seg_len_next} != 17'd6 + {8'd0, ns_next, 1'b0}) begin
                        err = 1'b1; ec = E_SOSLEN;
                    end
                    phase_next = P_SCAN;
                    emit = 1'b1; o_kind = K_SCANP;
                    o_idx = 8'(9'd3 + {ns_next, 1'b0}); o_val = {8'd0, b};
                end
                P_SCAN: begin
                    if (b == 8'hFF) phase_next = P_SCAN_FF;
                    else begin
                        emit = 1'b1; o_kind = K_DATA; o_val = {8'd0, b};
                    end
                end
                P_SCAN_FF: begin
                    if (b == 8'hD9) begin
                        fc = final_check(ncomp_next, qid_next, dcid_next, acid_next,
                                         qset_next, dcset_next, acset_next);
                        err = 1'b1; ec = fc;
                    end else if (b == 8'h00) begin
                        phase_next = P_SCAN;
                        emit = 1'b1; o_kind = K_DATA; o_val = 16'h00FF;
                    end else if (b >= 8'hD0 && b <= 8'hD7) phase_next = P_SCAN;
                    else if (b != 8'hFF) begin err = 1'b1; ec = E_BADSCAN; end
                end
                default: phase_next = ph;
            endcase
        end

        // An error replaces any item of the same byte with one status transfer.
        if (err) begin
            phase_next = P_DONE;
            emit = 1'b1; o_kind = K_STAT; o_sel = 3'd0; o_idx = 8'd0; o_val = 16'd0;
        end
        o_stat = err ? ec : 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_SOI1;
            seg_reg <= SEG_SKIP;
            seg_len_reg <= '0; acc_reg <= '0; hz_reg <= 1'b0; cnt_reg <= '0;
            total_reg <= '0; remain_reg <= '0; ncomp_reg <= '0; zb_reg <= 1'b0;
            used_reg <= '0; cur_reg <= '0; tsel_reg <= '0; wide_reg <= 1'b0;
            ns_reg <= '0; ss_reg <= '0; se_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                qid_reg[i] <= '0; dcid_reg[i] <= '0; acid_reg[i] <= '0;
            end
            qset_reg <= '0; dcset_reg <= '0; acset_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next; seg_reg <= seg_next;
                seg_len_reg <= seg_len_next; acc_reg <= acc_next; hz_reg <= hz_next;
                cnt_reg <= cnt_next; total_reg <= total_next; remain_reg <= remain_next;
                ncomp_reg <= ncomp_next; zb_reg <= zb_next; used_reg <= used_next;
                cur_reg <= cur_next; tsel_reg <= tsel_next; wide_reg <= wide_next;
                ns_reg <= ns_next; ss_reg <= ss_next; se_reg <= se_next;
                for (int i = 0; i < 3; i++) begin
                    qid_reg[i] <= qid_next[i]; dcid_reg[i] <= dcid_next[i];
                    acid_reg[i] <= acid_next[i];
                end
                qset_reg <= qset_next; dcset_reg <= dcset_next; acset_reg <= acset_next;
                ov_reg <= emit;
            end else if (m_axis_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            od_reg <= {o_stat, o_val, o_idx, o_sel, o_kind};
        end
    end

    a_stat_only_kind7: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != K_STAT |-> m_axis_tdata[35:30] == 6'd0)
        else $error("status set on a non-status transfer");
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && o_stat != 6'd0 |=> phase_reg == P_DONE)
        else $error("error did not stop the parser");
    a_no_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == P_DONE && !s_axis_tuser[0] |-> !emit)
        else $error("transfer produced after end of file");

endmodule
